FILE: design/tpsg_pkg.sv
// ----------------------------------------------------------------------------
// tpsg_pkg
// Shared types, register indexes and the sine table of the gate drive.
// ----------------------------------------------------------------------------
package tpsg_pkg;

	localparam int unsigned SINE_ENTRIES = 360;
	localparam int unsigned SINE_HALF    = 180;
	localparam int unsigned COUNT_W      = 8;
	localparam int unsigned POS_W        = 9;
	localparam int unsigned DEAD_W       = 6;
	localparam int unsigned CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FORWARD   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME = 1'd1;

	localparam logic [DEAD_W-1:0] DEAD_TIME_RESET = 6'd8;

	// First half of the period; the second half mirrors it about 128.
	localparam logic [7:0] SINE_LO [0:SINE_HALF-1] = '{
		8'd128, 8'd132, 8'd136, 8'd140, 8'd143, 8'd147, 8'd151, 8'd155, 8'd159, 8'd162,
		8'd166, 8'd170, 8'd174, 8'd178, 8'd181, 8'd185, 8'd189, 8'd192, 8'd196, 8'd200,
		8'd203, 8'd207, 8'd211, 8'd214, 8'd218, 8'd221, 8'd225, 8'd228, 8'd232, 8'd235,
		8'd238, 8'd239, 8'd240, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247,
		8'd248, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253,
		8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254,
		8'd253, 8'd253, 8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248,
		8'd248, 8'd247, 8'd246, 8'd245, 8'd244, 8'd243, 8'd242, 8'd241, 8'd240, 8'd239,
		8'd238, 8'd239, 8'd240, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247,
		8'd248, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253,
		8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254,
		8'd253, 8'd253, 8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248,
		8'd248, 8'd247, 8'd246, 8'd245, 8'd244, 8'd243, 8'd242, 8'd241, 8'd240, 8'd239,
		8'd238, 8'd235, 8'd232, 8'd228, 8'd225, 8'd221, 8'd218, 8'd214, 8'd211, 8'd207,
		8'd203, 8'd200, 8'd196, 8'd192, 8'd189, 8'd185, 8'd181, 8'd178, 8'd174, 8'd170,
		8'd166, 8'd162, 8'd159, 8'd155, 8'd151, 8'd147, 8'd143, 8'd140, 8'd136, 8'd132
	};

	function automatic logic [7:0] sine_value(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] off;
		logic [8:0]       mirror;
		begin
			off    = pos - POS_W'(SINE_HALF);
			mirror = 9'd256 - {1'b0, SINE_LO[off[7:0]]};
			if (pos < POS_W'(SINE_HALF)) begin
				sine_value = SINE_LO[pos[7:0]];
			end else begin
				sine_value = mirror[7:0];
			end
		end
	endfunction

	// Beat held between the rotor stage and the gate stage.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               reload;
		logic [POS_W-1:0]   pos_a;
		logic [POS_W-1:0]   pos_b;
		logic [POS_W-1:0]   pos_c;
		logic [POS_W-1:0]   rotor_index;
	} tpsg_s2_t;

endpackage

FILE: design/three_phase_sine_pwm_gate_drive.sv
// ----------------------------------------------------------------------------
// three_phase_sine_pwm_gate_drive
// Three-phase sine PWM gate drive with dead time.
// ----------------------------------------------------------------------------
// Each input beat on s_axis is one tick of the PWM counter: pwm_count and a
// step_pulse that moves the rotor index by one place. Each tick gives exactly
// one result beat on m_axis with the six gate drives and the rotor index.
// m_tvalid rises behind an input register, a register after the rotor update
// and table mapping, and the output register. A beat can be taken every cycle
// while the receiver does not stall; the rate is one tick per clock, set by
// the rotor index loop. When the receiver stalls, results stay in the output
// register and the two stages behind it fill before s_tready falls; nothing is
// dropped. Reset clears the valid flags of all stages, sets the rotor index to
// one, all widths to zero, forward to 0 and dead_time to 8. The cfg port
// writes forward (index 0) and dead_time (index 1) on any cycle with cfg_we
// high. The user must write them only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module three_phase_sine_pwm_gate_drive
	import tpsg_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = 360
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // pwm_count[7:0], step_pulse[8], zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // high_a, low_a, high_b, low_b, high_c,
	                                        // low_c, rotor_index[14:6], zero
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DEAD_W-1:0]    cfg_data
);

	logic               forward_q;
	logic [DEAD_W-1:0]  dead_time_q;

	logic               valid_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               step_s1;
	logic               valid_s2;
	tpsg_s2_t           beat_s2;
	logic               out_valid_q;
	logic [15:0]        out_data_q;

	logic ready_out;
	logic ready_s2;
	logic ready_s1;
	logic go_s1;
	logic go_s2;

	tpsg_s2_t           beat_next;
	logic [POS_W-1:0]   pos_a;
	logic [POS_W-1:0]   pos_b;
	logic [POS_W-1:0]   pos_c;
	logic [POS_W-1:0]   rotor_index;
	logic [8:0]         window_sum;
	logic [5:0]         gates;

	assign ready_out = !out_valid_q || m_tready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign s_tready  = ready_s1;
	assign go_s1     = valid_s1 && ready_s2;
	assign go_s2     = valid_s2 && ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_q   <= 1'b0;
			dead_time_q <= DEAD_TIME_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FORWARD:   forward_q   <= cfg_data[0];
				CFG_DEAD_TIME: dead_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && ready_s1) begin
			count_s1 <= s_tdata[7:0];
			step_s1  <= s_tdata[8];
		end
		if (go_s1) begin
			beat_s2 <= beat_next;
		end
		if (go_s2) begin
			out_data_q <= {1'b0, beat_s2.rotor_index, gates};
		end
	end

	tpsg_rotor #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_rotor (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (go_s1),
		.step        (step_s1),
		.forward     (forward_q),
		.pos_a       (pos_a),
		.pos_b       (pos_b),
		.pos_c       (pos_c),
		.rotor_index (rotor_index)
	);

	// Reload window: count above 255 minus the dead time.
	assign window_sum = {1'b0, count_s1} + 9'(dead_time_q);

	always_comb begin
		beat_next.count       = count_s1;
		beat_next.reload      = window_sum[8];
		beat_next.pos_a       = pos_a;
		beat_next.pos_b       = pos_b;
		beat_next.pos_c       = pos_c;
		beat_next.rotor_index = rotor_index;
	end

	tpsg_phase u_phase_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (go_s2),
		.reload    (beat_s2.reload),
		.pos       (beat_s2.pos_a),
		.count     (beat_s2.count),
		.dead_time (dead_time_q),
		.high      (gates[0]),
		.low       (gates[1])
	);

	tpsg_phase u_phase_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (go_s2),
		.reload    (beat_s2.reload),
		.pos       (beat_s2.pos_b),
		.count     (beat_s2.count),
		.dead_time (dead_time_q),
		.high      (gates[2]),
		.low       (gates[3])
	);

	tpsg_phase u_phase_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (go_s2),
		.reload    (beat_s2.reload),
		.pos       (beat_s2.pos_c),
		.count     (beat_s2.count),
		.dead_time (dead_time_q),
		.high      (gates[4]),
		.low       (gates[5])
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: design/tpsg_rotor.sv
// ----------------------------------------------------------------------------
// tpsg_rotor
// Rotor index state, phase offsets and mapping onto the sine table.
// ----------------------------------------------------------------------------
module tpsg_rotor
	import tpsg_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = 360
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             step,
	input  logic             forward,
	output logic [POS_W-1:0] pos_a,
	output logic [POS_W-1:0] pos_b,
	output logic [POS_W-1:0] pos_c,
	output logic [POS_W-1:0] rotor_index
);

	localparam int unsigned IW        = $clog2(TABLE_SIZE);
	localparam int unsigned SHIFT     = TABLE_SIZE / 3;
	localparam int unsigned MAP_SH    = 21;
	localparam int unsigned MAP_MUL   = (SINE_ENTRIES * (2 ** MAP_SH) + TABLE_SIZE - 1)
		/ TABLE_SIZE;
	localparam int unsigned PROD_W    = IW + 32;

	logic [IW-1:0] rotor_q;
	logic [IW-1:0] rotor_next;
	logic [IW:0]   sum_b;
	logic [IW:0]   sum_c;
	logic [IW-1:0] idx_b;
	logic [IW-1:0] idx_c;

	// Scale an index of this table onto the 360-entry sine table by a
	// fixed-point reciprocal; the fraction is wide enough to be exact.
	function automatic logic [POS_W-1:0] map_pos(input logic [IW-1:0] idx);
		logic [PROD_W-1:0] prod;
		logic [9:0]        raw;
		begin
			prod = PROD_W'(idx) * PROD_W'(MAP_MUL);
			raw  = prod[MAP_SH +: 10];
			if (raw >= 10'(SINE_ENTRIES)) begin
				map_pos = POS_W'(SINE_ENTRIES - 1);
			end else begin
				map_pos = raw[POS_W-1:0];
			end
		end
	endfunction

	always_comb begin
		rotor_next = rotor_q;
		if (step) begin
			if (forward) begin
				rotor_next = (rotor_q == '0) ? IW'(TABLE_SIZE - 1) : rotor_q - 1'b1;
			end else begin
				rotor_next = ({1'b0, rotor_q} + 1'b1 >= (IW+1)'(TABLE_SIZE)) ? '0
					: rotor_q + 1'b1;
			end
		end
	end

	always_comb begin
		sum_b = {1'b0, rotor_next} + (IW+1)'(SHIFT);
		sum_c = {1'b0, rotor_next} + (IW+1)'(2 * SHIFT);
		idx_b = (sum_b >= (IW+1)'(TABLE_SIZE)) ? IW'(sum_b - (IW+1)'(TABLE_SIZE))
			: sum_b[IW-1:0];
		idx_c = (sum_c >= (IW+1)'(TABLE_SIZE)) ? IW'(sum_c - (IW+1)'(TABLE_SIZE))
			: sum_c[IW-1:0];
	end

	assign pos_a       = map_pos(rotor_next);
	assign pos_b       = map_pos(idx_b);
	assign pos_c       = map_pos(idx_c);
	assign rotor_index = POS_W'(rotor_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_q <= IW'(1 % TABLE_SIZE);
		end else if (advance) begin
			rotor_q <= rotor_next;
		end
	end

endmodule

FILE: design/tpsg_phase.sv
// ----------------------------------------------------------------------------
// tpsg_phase
// One phase: held pulse width, sine reload and the two gate drives.
// ----------------------------------------------------------------------------
module tpsg_phase
	import tpsg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               reload,
	input  logic [POS_W-1:0]   pos,
	input  logic [COUNT_W-1:0] count,
	input  logic [DEAD_W-1:0]  dead_time,
	output logic               high,
	output logic               low
);

	logic [7:0] width_q;
	logic [7:0] width_cur;
	logic [8:0] low_start;

	assign width_cur = reload ? sine_value(pos) : width_q;
	assign low_start = {1'b0, width_cur} + 9'(dead_time);

	// Outside the reload window the count is at most 255 minus the dead time.
	assign high = count < width_cur;
	assign low  = ({1'b0, count} > low_start) && !reload;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
		end else if (advance && reload) begin
			width_q <= width_cur;
		end
	end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-phase sine PWM gate drive.
// ----------------------------------------------------------------------------
// PWM ticks go in on s_axis and gate beats come out on m_axis. Both sides idle
// and stall at random. A bench-side model of the rotor index, the sine widths
// and the dead-time windows predicts each gate beat, and every beat is checked
// field by field. A short directed plan covers the reset state, the reload
// window edges, wrapping in both directions and the dead-time extremes. Random
// PWM ramps with step pulses under several direction and dead-time settings
// follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import tpsg_pkg::*;

	localparam int ROTOR_SPAN   = 360;
	localparam int THIRD_TURN   = ROTOR_SPAN / 3;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_TICKS  = 185;

	localparam logic [7:0] SINE_TABLE [0:359] = '{
		8'd128, 8'd132, 8'd136, 8'd140, 8'd143, 8'd147, 8'd151, 8'd155, 8'd159, 8'd162,
		8'd166, 8'd170, 8'd174, 8'd178, 8'd181, 8'd185, 8'd189, 8'd192, 8'd196, 8'd200,
		8'd203, 8'd207, 8'd211, 8'd214, 8'd218, 8'd221, 8'd225, 8'd228, 8'd232, 8'd235,
		8'd238, 8'd239, 8'd240, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247,
		8'd248, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253,
		8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254,
		8'd253, 8'd253, 8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248,
		8'd248, 8'd247, 8'd246, 8'd245, 8'd244, 8'd243, 8'd242, 8'd241, 8'd240, 8'd239,
		8'd238, 8'd239, 8'd240, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247,
		8'd248, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253,
		8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254,
		8'd253, 8'd253, 8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248,
		8'd248, 8'd247, 8'd246, 8'd245, 8'd244, 8'd243, 8'd242, 8'd241, 8'd240, 8'd239,
		8'd238, 8'd235, 8'd232, 8'd228, 8'd225, 8'd221, 8'd218, 8'd214, 8'd211, 8'd207,
		8'd203, 8'd200, 8'd196, 8'd192, 8'd189, 8'd185, 8'd181, 8'd178, 8'd174, 8'd170,
		8'd166, 8'd162, 8'd159, 8'd155, 8'd151, 8'd147, 8'd143, 8'd140, 8'd136, 8'd132,
		8'd128, 8'd124, 8'd120, 8'd116, 8'd113, 8'd109, 8'd105, 8'd101, 8'd97,  8'd94,
		8'd90,  8'd86,  8'd82,  8'd78,  8'd75,  8'd71,  8'd67,  8'd64,  8'd60,  8'd56,
		8'd53,  8'd49,  8'd45,  8'd42,  8'd38,  8'd35,  8'd31,  8'd28,  8'd24,  8'd21,
		8'd18,  8'd17,  8'd16,  8'd15,  8'd14,  8'd13,  8'd12,  8'd11,  8'd10,  8'd9,
		8'd8,   8'd8,   8'd7,   8'd6,   8'd6,   8'd5,   8'd4,   8'd4,   8'd3,   8'd3,
		8'd3,   8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
		8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd5,   8'd6,   8'd6,   8'd7,   8'd8,
		8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,  8'd17,
		8'd18,  8'd17,  8'd16,  8'd15,  8'd14,  8'd13,  8'd12,  8'd11,  8'd10,  8'd9,
		8'd8,   8'd8,   8'd7,   8'd6,   8'd6,   8'd5,   8'd4,   8'd4,   8'd3,   8'd3,
		8'd3,   8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
		8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd5,   8'd6,   8'd6,   8'd7,   8'd8,
		8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,  8'd17,
		8'd18,  8'd21,  8'd24,  8'd28,  8'd31,  8'd35,  8'd38,  8'd42,  8'd45,  8'd49,
		8'd53,  8'd56,  8'd60,  8'd64,  8'd67,  8'd71,  8'd75,  8'd78,  8'd82,  8'd86,
		8'd90,  8'd94,  8'd97,  8'd101, 8'd105, 8'd109, 8'd113, 8'd116, 8'd120, 8'd124
	};

	// Same layout as m_tdata[14:0]: the last member sits in bit 0.
	typedef struct packed {
		logic [POS_W-1:0] rotor_index;
		logic             low_c;
		logic             high_c;
		logic             low_b;
		logic             high_b;
		logic             low_a;
		logic             high_a;
	} gate_beat_t;

	typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [COUNT_W-1:0]   cnt;
		logic                 stp;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [DEAD_W-1:0]    reg_val;
		bit                   known;
		gate_beat_t           want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // pwm_count[7:0], step_pulse[8], zero
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;   // high_a, low_a, high_b, low_b, high_c,
	                                 // low_c, rotor_index[14:6], zero
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DEAD_W-1:0]    cfg_data;

	// Bench copy of the drive state and its registers.
	logic [POS_W-1:0]   rotor_pos   = 9'd1;
	logic [7:0]         wid_a       = 8'd0;
	logic [7:0]         wid_b       = 8'd0;
	logic [7:0]         wid_c       = 8'd0;
	logic               drv_forward = 1'b0;
	logic [DEAD_W-1:0]  drv_dead    = DEAD_TIME_RESET;

	gate_beat_t gate_due_q [$];
	plan_row_t  plan [$];
	int         beats_seen = 0;
	int         bad_beats  = 0;
	bit         squeezed   = 0;

	three_phase_sine_pwm_gate_drive DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [7:0] sine_at(input int idx);
		return SINE_TABLE[idx % ROTOR_SPAN];
	endfunction

	// Returns {low, high} for one phase.
	function automatic logic [1:0] phase_gates(input logic [7:0] cnt, input logic [7:0] wid);
		int win_end;
		win_end = 255 - int'(drv_dead);
		return {(int'(cnt) > int'(wid) + int'(drv_dead)) && (int'(cnt) <= win_end),
		        int'(cnt) < int'(wid)};
	endfunction

	function automatic gate_beat_t predict_gates(input logic [7:0] cnt, input logic stp);
		gate_beat_t res;
		if (stp) begin
			if (drv_forward)
				rotor_pos = (rotor_pos == 9'd0) ? 9'(ROTOR_SPAN - 1) : rotor_pos - 9'd1;
			else
				rotor_pos = (int'(rotor_pos) + 1 >= ROTOR_SPAN) ? 9'd0 : rotor_pos + 9'd1;
		end
		// Widths reload from the new index once the count enters the top window.
		if (int'(cnt) > 255 - int'(drv_dead)) begin
			wid_a = sine_at(int'(rotor_pos));
			wid_b = sine_at(int'(rotor_pos) + THIRD_TURN);
			wid_c = sine_at(int'(rotor_pos) + 2 * THIRD_TURN);
		end
		{res.low_a, res.high_a} = phase_gates(cnt, wid_a);
		{res.low_b, res.high_b} = phase_gates(cnt, wid_b);
		{res.low_c, res.high_c} = phase_gates(cnt, wid_c);
		res.rotor_index = rotor_pos;
		return res;
	endfunction

	// Mostly short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic plan_row_t row_tick(input logic [7:0] cnt, input logic stp);
		plan_row_t row;
		row = '{ROW_TICK, cnt, stp, '0, '0, 1'b0, '0};
		return row;
	endfunction

	function automatic plan_row_t row_known(input logic [7:0] cnt, input logic stp,
	                                        input gate_beat_t want);
		plan_row_t row;
		row = '{ROW_TICK, cnt, stp, '0, '0, 1'b1, want};
		return row;
	endfunction

	function automatic plan_row_t row_reg(input logic [CFG_IDX_W-1:0] idx,
	                                      input logic [DEAD_W-1:0] val);
		plan_row_t row;
		row = '{ROW_REG, '0, 1'b0, idx, val, 1'b0, '0};
		return row;
	endfunction

	task automatic send_tick(input logic [7:0] cnt, input logic stp, input bit may_idle,
	                         input bit known, input gate_beat_t want);
		int gap;
		gate_beat_t due;
		gap = (may_idle && $urandom_range(0, 99) >= 60) ? idle_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, stp, cnt};
		do @(posedge clk); while (!s_tready);
		due = predict_gates(cnt, stp);
		gate_due_q.push_back(known ? want : due);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (gate_due_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DEAD_W-1:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FORWARD)
			drv_forward = val[0];
		else
			drv_dead = val;
	endtask

	// Stimulus.
	initial begin
		logic [7:0] cnt;
		int         left;
		int         len;
		int         period;
		bit         steady;
		logic       ph_fwd  [7];
		logic [5:0] ph_dead [7];

		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_FORWARD;
		cfg_data  <= '0;

		// Reset state: zero widths, rotor at one; then a reload from index one.
		plan.push_back(row_known(8'd0,   1'b0, gate_beat_t'({9'd1, 6'b000000})));
		plan.push_back(row_known(8'd255, 1'b0, gate_beat_t'({9'd1, 6'b000000})));
		plan.push_back(row_known(8'd0,   1'b0, gate_beat_t'({9'd1, 6'b010101})));
		plan.push_back(row_known(8'd247, 1'b0, gate_beat_t'({9'd1, 6'b100110})));
		plan.push_back(row_tick(8'd248, 1'b1));
		plan.push_back(row_tick(8'd128, 1'b1));
		// Stepping down through zero wraps to the top of the table.
		plan.push_back(row_reg(CFG_FORWARD, 6'd1));
		plan.push_back(row_tick(8'd10, 1'b1));
		plan.push_back(row_tick(8'd20, 1'b1));
		plan.push_back(row_tick(8'd30, 1'b1));
		plan.push_back(row_tick(8'd255, 1'b1));
		plan.push_back(row_tick(8'd100, 1'b0));
		// And stepping up from the top wraps back to zero.
		plan.push_back(row_reg(CFG_FORWARD, 6'd0));
		plan.push_back(row_tick(8'd255, 1'b1));
		plan.push_back(row_reg(CFG_DEAD_TIME, 6'd0));
		plan.push_back(row_tick(8'd255, 1'b0));
		plan.push_back(row_tick(8'd254, 1'b0));
		plan.push_back(row_reg(CFG_DEAD_TIME, 6'd63));
		plan.push_back(row_tick(8'd193, 1'b0));
		plan.push_back(row_tick(8'd192, 1'b0));
		plan.push_back(row_tick(8'd64, 1'b1));
		plan.push_back(row_tick(8'd0, 1'b1));

		ph_fwd  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom_range(0, 1))};
		ph_dead = '{6'd0, 6'd63, 6'd31, 6'd1, 6'd62, 6'd8, 6'($urandom_range(0, 63))};

		@(posedge arst_n);
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			else
				send_tick(plan[i].cnt, plan[i].stp, 1'b1, plan[i].known, plan[i].want);
		end

		foreach (ph_fwd[p]) begin
			write_reg(CFG_FORWARD, {5'd0, ph_fwd[p]});
			write_reg(CFG_DEAD_TIME, ph_dead[p]);
			left = PHASE_TICKS;
			while (left > 0) begin
				if ($urandom_range(0, 9) < 8) begin
					// A run of the free-running counter with step pulses now and then.
					cnt    = 8'($urandom_range(0, 255));
					len    = $urandom_range(20, 300);
					period = $urandom_range(1, 24);
					steady = ($urandom_range(0, 3) == 0);
					if (len > left) len = left;
					repeat (len) begin
						send_tick(cnt, $urandom_range(1, period) == 1, !steady, 1'b0, '0);
						cnt = cnt + 8'd1;
					end
				end else begin
					// Counter jumping about at random.
					len = $urandom_range(1, 20);
					if (len > left) len = left;
					repeat (len)
						send_tick(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						          1'b1, 1'b0, '0);
				end
				left = left - len;
			end
		end

		s_tvalid <= 1'b0;
		while (gate_due_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (bad_beats == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver: random stalls, calm stretches, and one long hold-off that backs
	// the pipeline up into s_tready.
	initial begin
		int hold;
		int calm;
		int r;
		hold = 0;
		calm = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!squeezed && beats_seen >= 400) begin
				squeezed = 1;
				hold     = 100;
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else if (calm > 0) begin
				m_tready <= 1'b1;
				calm--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					m_tready <= 1'b1;
					calm = $urandom_range(30, 80);
				end else if (r < 70) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					hold = idle_len() - 1;
				end
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		gate_beat_t got;
		gate_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = gate_beat_t'(m_tdata[14:0]);
			beats_seen++;
			if (gate_due_q.size() == 0) begin
				bad_beats++;
				if (bad_beats <= 10)
					$display("beat %0d arrived with nothing expected: %p", beats_seen, got);
			end else begin
				want = gate_due_q.pop_front();
				if (got.high_a != want.high_a || got.low_a != want.low_a ||
				    got.high_b != want.high_b || got.low_b != want.low_b ||
				    got.high_c != want.high_c || got.low_c != want.low_c ||
				    got.rotor_index != want.rotor_index) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("beat %0d mismatch: expected %p, got %p",
						         beats_seen, want, got);
				end
			end
		end
	end

endmodule

FILE: three_phase_sine_pwm_gate_drive.f
design/tpsg_pkg.sv
design/tpsg_rotor.sv
design/tpsg_phase.sv
design/three_phase_sine_pwm_gate_drive.sv
test/tb.sv
